/* hw/rtl/nsm_pkg.sv */
// nsm_pkg: shared types and constants of the nearest sign matcher
// item and result structs, sign table entry, register indexes, sequencer states
// no dependencies
package nsm_pkg;

   localparam int POS_W      = 20;
   localparam int TYPE_W     = 8;
   localparam int RADIUS_W   = 16;
   localparam int ABS_W      = POS_W + 1;
   localparam int SQ_W       = 2 * POS_W + 1;
   localparam int DIST_W     = SQ_W + 1;
   localparam int OUT_IDX_W  = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [1:0] KIND_CLEAR  = 2'd0;
   localparam logic [1:0] KIND_APPEND = 2'd1;
   localparam logic [1:0] KIND_MATCH  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_MATCH_RADIUS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_TYPE = 2'd1;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd1000;
   localparam logic [TYPE_W-1:0]   DEFAULT_TYPE_RESET = 8'd0;

   typedef struct packed {
      logic [1:0]              kind;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic [TYPE_W-1:0]       sign_type;
   } req_type;

   typedef struct packed {
      logic                 status;
      logic                 matched;
      logic [TYPE_W-1:0]    matched_type;
      logic [OUT_IDX_W-1:0] matched_index;
   } rsp_type;

   // one slot of the sign table; used marks a sign consumed by a match
   typedef struct packed {
      logic                    used;
      logic [TYPE_W-1:0]       sign_type;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_x;
   } sign_entry_type;

   // distance pipeline output for one slot
   typedef struct packed {
      logic              valid;
      logic              used;
      logic [TYPE_W-1:0] sign_type;
      logic [DIST_W-1:0] span_sq;
   } dist_tag_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

endpackage

/* hw/rtl/nsm_sign_mem.sv */
// nsm_sign_mem: sign table, one write port and one registered read port
// uses nsm_pkg for the entry type
module nsm_sign_mem #(
   parameter int DEPTH = 64,
   parameter int IDX_W = 6
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [IDX_W-1:0]       wr_addr,
   input  nsm_pkg::sign_entry_type wr_data,
   input  logic                   rd_en,
   input  logic [IDX_W-1:0]       rd_addr,
   output nsm_pkg::sign_entry_type rd_data
);
   import nsm_pkg::*;

   sign_entry_type mem_ff [DEPTH];
   sign_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/nsm_dist_unit.sv */
// nsm_dist_unit: pipelined squared distance from the entry point to each read slot
// uses nsm_pkg; takes read data in the cycle after the matching read issue
module nsm_dist_unit #(
   parameter int IDX_W = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          issue_valid,
   input  logic [IDX_W-1:0]              issue_idx,
   input  nsm_pkg::sign_entry_type       rd_entry,
   input  logic signed [nsm_pkg::POS_W-1:0] point_x,
   input  logic signed [nsm_pkg::POS_W-1:0] point_y,
   output nsm_pkg::dist_tag_type         result,
   output logic [IDX_W-1:0]              result_idx,
   output logic                          busy
);
   import nsm_pkg::*;

   logic             v1_ff, v2_ff, v3_ff;
   logic [IDX_W-1:0] idx1_ff, idx2_ff, idx3_ff;
   logic             used2_ff, used3_ff;
   logic [TYPE_W-1:0] type2_ff, type3_ff;
   logic [ABS_W-1:0] ax2_ff, ay2_ff;
   logic [SQ_W-1:0]  sqx3_ff, sqy3_ff;

   logic [ABS_W-1:0] dx, dy, ax_in, ay_in;
   logic [2*ABS_W-1:0] sqx_full, sqy_full;

   // differences in 21 bits, then magnitude; the most negative case fits unsigned
   always_comb begin
      dx = {rd_entry.pos_x[POS_W-1], rd_entry.pos_x} - {point_x[POS_W-1], point_x};
      dy = {rd_entry.pos_y[POS_W-1], rd_entry.pos_y} - {point_y[POS_W-1], point_y};
      ax_in = dx[ABS_W-1] ? (~dx + ABS_W'(1)) : dx;
      ay_in = dy[ABS_W-1] ? (~dy + ABS_W'(1)) : dy;
      sqx_full = ax2_ff * ax2_ff;
      sqy_full = ay2_ff * ay2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= issue_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      idx1_ff  <= issue_idx;
      idx2_ff  <= idx1_ff;
      used2_ff <= rd_entry.used;
      type2_ff <= rd_entry.sign_type;
      ax2_ff   <= ax_in;
      ay2_ff   <= ay_in;
      idx3_ff  <= idx2_ff;
      used3_ff <= used2_ff;
      type3_ff <= type2_ff;
      sqx3_ff  <= sqx_full[SQ_W-1:0];
      sqy3_ff  <= sqy_full[SQ_W-1:0];
   end

   always_comb begin
      result.valid     = v3_ff;
      result.used      = used3_ff;
      result.sign_type = type3_ff;
      result.span_sq   = DIST_W'(sqx3_ff) + DIST_W'(sqy3_ff);
   end

   assign result_idx = idx3_ff;
   assign busy       = v1_ff | v2_ff | v3_ff;

endmodule

/* hw/rtl/nearest_sign_matcher_unit.sv */
// nearest_sign_matcher_unit: top level, sequencer, best-candidate tracking, registers
// uses nsm_pkg, nsm_sign_mem, nsm_dist_unit
//
// usage:
//   req channel (req_valid/req_stall/req_data) takes clear, append and match items;
//   rsp channel (rsp_valid/rsp_stall/rsp_data) returns exactly one result per item.
//   csr channel writes match_radius (index 0) and default_sign_type (index 1);
//   csr_ready is always high, writes are expected only while the block is idle.
// result timing and throughput:
//   clear, append and the unused kind give their result in the cycle after acceptance
//   and a new item can be taken every cycle while the result register drains.
//   a match reads the sign table once per appended slot, one slot per cycle through
//   the single read port, then runs the drain and finish states and writes the used
//   mark back when a sign was found.
//   one item is in flight at a time; req_stall is high while a match runs.
// reset: sign count, registers and control clear; the table needs no
//   clearing pass since slots at or above the count are never read.
// stall: a result holds in the output register while rsp_stall is high; a new item
//   is taken only when that register is empty or being read out in the same cycle.
module nearest_sign_matcher_unit #(
   parameter int MAX_SIGNS = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  nsm_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output nsm_pkg::rsp_type                   rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [nsm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [nsm_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import nsm_pkg::*;

   localparam int IDX_W = (MAX_SIGNS > 1) ? $clog2(MAX_SIGNS) : 1;
   localparam int CNT_W = $clog2(MAX_SIGNS + 1);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  sign_count_ff, sign_count_in;
   logic [IDX_W-1:0]  scan_ff, scan_in;
   logic [RADIUS_W-1:0] radius_ff;
   logic [TYPE_W-1:0] default_type_ff;
   logic signed [POS_W-1:0] px_ff, py_ff;
   logic [DIST_W-1:0] best_ff;
   logic [IDX_W-1:0]  best_idx_ff;
   logic [TYPE_W-1:0] best_type_ff;
   logic              found_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff;

   logic              out_free, req_take, table_full, scan_last;
   logic              rd_en, mem_we, load;
   logic [IDX_W-1:0]  mem_waddr;
   sign_entry_type    mem_wdata, rd_entry;
   rsp_type           load_data;
   dist_tag_type      dist_res;
   logic [IDX_W-1:0]  dist_idx;
   logic              pipe_busy, better;
   logic [2*RADIUS_W-1:0] radius_sq;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_take   = req_valid && !req_stall;
   assign table_full = (sign_count_ff == CNT_W'(MAX_SIGNS));
   assign scan_last  = ((CNT_W'(scan_ff) + CNT_W'(1)) == sign_count_ff);
   assign radius_sq  = radius_ff * radius_ff;
   assign better     = dist_res.valid && !dist_res.used && (dist_res.span_sq < best_ff);
   assign csr_ready  = 1'b1;

   nsm_sign_mem #(
      .DEPTH (MAX_SIGNS),
      .IDX_W (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (rd_en),
      .rd_addr (scan_ff),
      .rd_data (rd_entry)
   );

   nsm_dist_unit #(
      .IDX_W (IDX_W)
   ) u_dist (
      .clock       (clock),
      .reset       (reset),
      .issue_valid (rd_en),
      .issue_idx   (scan_ff),
      .rd_entry    (rd_entry),
      .point_x     (px_ff),
      .point_y     (py_ff),
      .result      (dist_res),
      .result_idx  (dist_idx),
      .busy        (pipe_busy)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take && req_data.kind == KIND_MATCH) begin
               state_in = (sign_count_ff == '0) ? ST_DRAIN : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!pipe_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_stall = 1'b1;
      rd_en     = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = '0;
      mem_wdata = '0;
      load      = 1'b0;
      load_data = '0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = !out_free;
            if (req_take) begin
               case (req_data.kind)
                  KIND_CLEAR: load = 1'b1;
                  KIND_APPEND: begin
                     load = 1'b1;
                     if (table_full) begin
                        load_data.status = 1'b1;
                     end else begin
                        mem_we              = 1'b1;
                        mem_waddr           = IDX_W'(sign_count_ff);
                        mem_wdata.used      = 1'b0;
                        mem_wdata.sign_type = req_data.sign_type;
                        mem_wdata.pos_x     = req_data.pos_x;
                        mem_wdata.pos_y     = req_data.pos_y;
                     end
                  end
                  KIND_MATCH: load = 1'b0;
                  default: load = 1'b1;
               endcase
            end
         end
         ST_SCAN: rd_en = 1'b1;
         ST_DRAIN: rd_en = 1'b0;
         ST_FINISH: begin
            if (out_free) begin
               load                   = 1'b1;
               load_data.matched      = found_ff;
               load_data.matched_type = found_ff ? best_type_ff : default_type_ff;
               load_data.matched_index = found_ff ? OUT_IDX_W'(best_idx_ff) : '0;
               // write back the used mark of the chosen slot
               if (found_ff) begin
                  mem_we              = 1'b1;
                  mem_waddr           = best_idx_ff;
                  mem_wdata.used      = 1'b1;
                  mem_wdata.sign_type = best_type_ff;
               end
            end
         end
         default: req_stall = 1'b1;
      endcase
   end

   always_comb begin
      sign_count_in = sign_count_ff;
      if (req_take && req_data.kind == KIND_CLEAR) begin
         sign_count_in = '0;
      end else if (req_take && req_data.kind == KIND_APPEND && !table_full) begin
         sign_count_in = sign_count_ff + CNT_W'(1);
      end
      scan_in = (state_ff == ST_SCAN) ? scan_ff + IDX_W'(1) : '0;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         sign_count_ff   <= '0;
         scan_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
         found_ff        <= 1'b0;
         radius_ff       <= RADIUS_RESET;
         default_type_ff <= DEFAULT_TYPE_RESET;
      end else begin
         state_ff      <= state_in;
         sign_count_ff <= sign_count_in;
         scan_ff       <= scan_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MATCH_RADIUS: radius_ff <= csr_wdata[RADIUS_W-1:0];
               CSR_DEFAULT_TYPE: default_type_ff <= csr_wdata[TYPE_W-1:0];
               default: radius_ff <= radius_ff;
            endcase
         end
         if (req_take && req_data.kind == KIND_MATCH) begin
            found_ff <= 1'b0;
         end else if (better) begin
            found_ff <= 1'b1;
         end
      end
   end

   // match context and running best; strict compare keeps the lower index on ties
   always_ff @(posedge clock) begin
      if (req_take && req_data.kind == KIND_MATCH) begin
         px_ff   <= req_data.pos_x;
         py_ff   <= req_data.pos_y;
         best_ff <= DIST_W'(radius_sq);
      end else if (better) begin
         best_ff      <= dist_res.span_sq;
         best_idx_ff  <= dist_idx;
         best_type_ff <= dist_res.sign_type;
      end
      if (load) begin
         rsp_data_ff <= load_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> req_stall)
      else $error("item taken while a match is in progress");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      sign_count_ff <= CNT_W'(MAX_SIGNS))
      else $error("sign count beyond table depth");

   a_quick_rsp: assert property (@(posedge clock) disable iff (reset)
      req_take && req_data.kind != KIND_MATCH |=> rsp_valid)
      else $error("single-cycle item gave no result");

   a_best_in_table: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH && found_ff |-> CNT_W'(best_idx_ff) < sign_count_ff)
      else $error("matched slot outside filled part of table");
`endif

endmodule

/* sim/nearest_sign_matcher_unit_test.sv */
// nearest_sign_matcher_unit_test: self-checking bench for the nearest sign matcher
// drives clear, append, match and unused-kind items under random stalls, predicts each result in a
// tracker class and checks it field by field; depends on nsm_pkg and the unit's rtl
`timescale 1ns / 100ps

module nearest_sign_matcher_unit_test;
   import nsm_pkg::*;

   localparam int TABLE_DEPTH    = 64;
   localparam int POS_MAX        = 2 ** (POS_W - 1) - 1;
   localparam int POS_MIN        = -(2 ** (POS_W - 1));
   localparam int PHASES         = 6;
   localparam int PHASE_ITEMS    = 260;
   localparam int TAIL_CYCLES    = 80;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int REPORT_LIMIT   = 10;

   localparam logic [1:0]           KIND_UNUSED  = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;

   // mirror of the sign table; turns each accepted item into its expected result
   class sign_match_tracker;
      logic signed [POS_W-1:0] slot_x [TABLE_DEPTH];
      logic signed [POS_W-1:0] slot_y [TABLE_DEPTH];
      logic [TYPE_W-1:0]       slot_type [TABLE_DEPTH];
      bit                      slot_live [TABLE_DEPTH];
      int unsigned             fill_count;
      logic [RADIUS_W-1:0]     radius;
      logic [TYPE_W-1:0]       fallback_type;
      rsp_type                 pending_replies [$];
      int unsigned error_count, replies_checked;
      int unsigned clears, appends, drops, hits, misses, unused, writes;

      function new();
         foreach (slot_live[i]) slot_live[i] = 1'b0;
         fill_count = 0;
         radius = RADIUS_RESET;
         fallback_type = DEFAULT_TYPE_RESET;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         writes++;
         case (idx)
            CSR_MATCH_RADIUS: radius = data[RADIUS_W-1:0];
            CSR_DEFAULT_TYPE: fallback_type = data[TYPE_W-1:0];
            default: ;
         endcase
      endfunction

      function void accept_item(req_type item);
         rsp_type reply;
         longint  best_sq, span_sq, dx, dy;
         int      best;
         reply = '0;
         case (item.kind)
            KIND_CLEAR: begin
               foreach (slot_live[i]) slot_live[i] = 1'b0;
               fill_count = 0;
               clears++;
            end
            KIND_APPEND: begin
               appends++;
               if (fill_count >= TABLE_DEPTH) begin
                  reply.status = 1'b1;
                  drops++;
               end else begin
                  slot_x[fill_count] = item.pos_x;
                  slot_y[fill_count] = item.pos_y;
                  slot_type[fill_count] = item.sign_type;
                  slot_live[fill_count] = 1'b1;
                  fill_count++;
               end
            end
            KIND_MATCH: begin
               // a sign must lie strictly inside the radius; ties keep the lower slot
               best_sq = longint'(radius) * longint'(radius);
               best = -1;
               for (int i = 0; i < TABLE_DEPTH; i++) begin
                  if (slot_live[i]) begin
                     dx = longint'($signed(slot_x[i])) - longint'($signed(item.pos_x));
                     dy = longint'($signed(slot_y[i])) - longint'($signed(item.pos_y));
                     span_sq = dx * dx + dy * dy;
                     if (span_sq < best_sq) begin
                        best_sq = span_sq;
                        best = i;
                     end
                  end
               end
               if (best >= 0) begin
                  reply.matched = 1'b1;
                  reply.matched_type = slot_type[best];
                  reply.matched_index = OUT_IDX_W'(best);
                  slot_live[best] = 1'b0;
                  hits++;
               end else begin
                  reply.matched_type = fallback_type;
                  misses++;
               end
            end
            default: unused++;
         endcase
         pending_replies = {pending_replies, reply};
      endfunction

      function void check_reply(rsp_type got);
         rsp_type want;
         replies_checked++;
         if (pending_replies.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("unexpected result %0d: status %0b matched %0b type %02h slot %0d",
                        replies_checked, got.status, got.matched, got.matched_type,
                        got.matched_index);
            return;
         end
         want = pending_replies.pop_front();
         if (got.status !== want.status || got.matched !== want.matched ||
             got.matched_type !== want.matched_type ||
             got.matched_index !== want.matched_index) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("result %0d: want status %0b matched %0b type %02h slot %0d, %s",
                        replies_checked, want.status, want.matched, want.matched_type,
                        want.matched_index,
                        $sformatf("got status %0b matched %0b type %02h slot %0d",
                                  got.status, got.matched, got.matched_type,
                                  got.matched_index));
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   req_type                req_data;
   logic                   rsp_valid;
   logic                   rsp_stall;
   rsp_type                rsp_data;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   sign_match_tracker tracker;
   int unsigned items_sent;
   int unsigned phase_count;
   int unsigned idle_cycles;
   bit          quiet_tail;
   bit          sender_bursty;

   nearest_sign_matcher_unit #(.MAX_SIGNS(TABLE_DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // handshake monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) tracker.write_register(csr_index, csr_wdata);
         if (req_valid && !req_stall) tracker.accept_item(req_data);
         if (rsp_valid && !rsp_stall) tracker.check_reply(rsp_data);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // result side back-pressure in random bursts
   initial begin
      rsp_stall = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (quiet_tail || $urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   function automatic req_type item_of(logic [1:0] k, int x, int y, int t);
      req_type it;
      it.kind = k;
      it.pos_x = POS_W'(x);
      it.pos_y = POS_W'(y);
      it.sign_type = TYPE_W'(t);
      return it;
   endfunction

   function automatic int any_pos();
      return int'($urandom_range(0, 2 ** POS_W - 1)) + POS_MIN;
   endfunction

   function automatic int near(int center, int unsigned spread);
      int v;
      v = center + int'($urandom_range(0, 2 * spread)) - int'(spread);
      if (v > POS_MAX) v = POS_MAX;
      else if (v < POS_MIN) v = POS_MIN;
      return v;
   endfunction

   task automatic send_item(input req_type item);
      req_data <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      items_sent++;
      if (item.kind != KIND_UNUSED) phase_count++;
   endtask

   task automatic pace();
      if (!quiet_tail && sender_bursty && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   // hold off the sender until every result is back
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (tracker.replies_checked < items_sent);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic configure(input logic [RADIUS_W-1:0] r, input logic [TYPE_W-1:0] t);
      logic [7:0] upper;
      upper = 8'($urandom());
      // upper byte of the type write must be ignored
      csr_write(CSR_DEFAULT_TYPE, {upper, t});
      csr_write(CSR_MATCH_RADIUS, r);
      csr_write(CSR_SPARE_LO, 16'($urandom()));
      csr_write(CSR_SPARE_HI, 16'($urandom()));
      csr_valid <= 1'b0;
   endtask

   // one cluster of signs, then mostly matches around it with some noise
   task automatic run_scene(input int unsigned spread);
      int      cx, cy, fills, steps, pick;
      req_type item;
      if ($urandom_range(0, 5) == 0) begin
         cx = $urandom_range(0, 1) ? POS_MAX : POS_MIN;
         cy = $urandom_range(0, 1) ? POS_MAX : POS_MIN;
      end else begin
         cx = any_pos();
         cy = any_pos();
      end
      sender_bursty = $urandom_range(0, 2) != 0;
      if ($urandom_range(0, 4) != 0) begin
         send_item(item_of(KIND_CLEAR, any_pos(), any_pos(), $urandom_range(0, 255)));
         pace();
      end
      fills = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 16);
      for (int i = 0; i < fills; i++) begin
         send_item(item_of(KIND_APPEND, near(cx, spread), near(cy, spread),
                           $urandom_range(0, 255)));
         pace();
      end
      steps = $urandom_range(1, fills + 4);
      for (int i = 0; i < steps; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 70)
            item = item_of(KIND_MATCH, near(cx, spread), near(cy, spread), $urandom_range(0, 255));
         else if (pick < 80)
            item = item_of(KIND_APPEND, near(cx, spread), near(cy, spread), $urandom_range(0, 255));
         else if (pick < 86)
            item = item_of(KIND_MATCH, any_pos(), any_pos(), $urandom_range(0, 255));
         else if (pick < 90)
            item = item_of(KIND_UNUSED, any_pos(), any_pos(), $urandom_range(0, 255));
         else if (pick < 93)
            item = item_of(KIND_CLEAR, any_pos(), any_pos(), $urandom_range(0, 255));
         else
            item = item_of(KIND_APPEND, any_pos(), any_pos(), $urandom_range(0, 255));
         send_item(item);
         pace();
      end
   endtask

   initial begin
      logic [RADIUS_W-1:0] r;
      logic [TYPE_W-1:0]   t;
      tracker = new();
      items_sent = 0;
      phase_count = 0;
      quiet_tail = 1'b0;
      sender_bursty = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, corner positions, reuse, ties, radius edge, clear
      send_item(item_of(KIND_MATCH, 0, 0, 0));
      send_item(item_of(KIND_APPEND, POS_MIN, POS_MIN, 8'hff));
      send_item(item_of(KIND_APPEND, POS_MAX, POS_MAX, 8'h00));
      send_item(item_of(KIND_APPEND, 0, 0, 8'ha5));
      send_item(item_of(KIND_APPEND, 999, 0, 8'h5a));
      send_item(item_of(KIND_UNUSED, -1, -1, 8'hff));
      send_item(item_of(KIND_MATCH, 0, 0, 8'hff));
      send_item(item_of(KIND_MATCH, 0, 0, 0));
      send_item(item_of(KIND_MATCH, 0, 0, 0));
      send_item(item_of(KIND_MATCH, POS_MIN, POS_MIN, 0));
      send_item(item_of(KIND_MATCH, POS_MAX, POS_MAX, 0));
      send_item(item_of(KIND_APPEND, 500, 0, 8'h01));
      send_item(item_of(KIND_APPEND, -500, 0, 8'h02));
      send_item(item_of(KIND_APPEND, 600, 800, 8'h03));
      send_item(item_of(KIND_MATCH, 0, 0, 0));
      send_item(item_of(KIND_MATCH, 0, 0, 0));
      send_item(item_of(KIND_MATCH, 0, 0, 0));
      send_item(item_of(KIND_CLEAR, -1, -1, 8'hff));
      send_item(item_of(KIND_MATCH, 600, 800, 0));
      send_item(item_of(KIND_UNUSED, 0, 0, 0));
      settle();
      // zero radius never matches, even on the exact spot
      configure(16'd0, 8'h77);
      send_item(item_of(KIND_CLEAR, 0, 0, 0));
      send_item(item_of(KIND_APPEND, 0, 0, 8'h07));
      send_item(item_of(KIND_MATCH, 0, 0, 0));
      settle();
      configure(16'hffff, 8'hff);
      send_item(item_of(KIND_MATCH, 0, 0, 0));

      for (int p = 0; p < PHASES; p++) begin
         settle();
         t = 8'($urandom());
         case (p)
            0: r = 16'd1000;
            1: begin
               r = 16'hffff;
               t = 8'hff;
            end
            2: r = 16'($urandom_range(1, 65535));
            3: r = 16'd0;
            4: r = 16'($urandom_range(1, 40));
            default: r = 16'($urandom_range(200, 4000));
         endcase
         configure(r, t);
         quiet_tail = (p == PHASES - 1);
         phase_count = 0;
         while (phase_count < PHASE_ITEMS) run_scene(int'(r) + int'(r) / 2 + 3);
      end

      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d items: %0d clears, %0d appends (%0d dropped on a full table),",
               items_sent, tracker.clears, tracker.appends, tracker.drops);
      $display("  %0d matches hit, %0d missed, %0d unused kinds, %0d register writes",
               tracker.hits, tracker.misses, tracker.unused, tracker.writes);
      if (tracker.pending_replies.size() != 0)
         $display("%0d expected results never arrived", tracker.pending_replies.size());
      if (tracker.error_count == 0 && tracker.pending_replies.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatched or unexpected results", tracker.error_count);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
